### src/assert_macros.svh
// Assertion macros for the checker file sads_chk.
// Both macros sample on the rising edge of i_clk in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while i_rst_n is high.
`define SADS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SADS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/sads_pkg.sv
// Shared constants, codes and types for the double stack core.
// No dependencies; used by every module of the block except sads_ram.
`timescale 1ns / 1ps

package sads_pkg;

    localparam int DEPTH  = 32;
    localparam int ELEM_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // request codes; the fourth code is unused and acts as a no-op
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic SEL_LOWER = 1'b0;
    localparam logic SEL_UPPER = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ELEM_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic              vld;
        t_status           status;
        logic [ELEM_W-1:0] pop_value;
        logic [CNT_W-1:0]  total;
        logic              both_empty;
    } t_result;

endpackage

### src/shared_array_double_stack_core.sv
// Channel   Dir  Transfer on         Payload
// request   in   i_valid & o_ready   i_req_type, i_stack_sel, i_push_value
// result    out  o_valid & i_ready   o_status, o_pop_value, o_total_count, o_both_empty
//
// Push, clear and the unused code form their result when accepted; a
// successful pop forms it in S_READ from the store's registered read data.
// One request is in flight at a time, so a write never meets a read of the
// same entry in the same cycle.
// Reset (synchronous, active low) empties both stacks; the store is not cleared.
// A stalled result holds the output register and the request side waits.
// Depends on sads_pkg, sads_ram, sads_ctrl.
`timescale 1ns / 1ps

module shared_array_double_stack_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req_type,
    input  logic                          i_stack_sel,
    input  logic signed [sads_pkg::ELEM_W-1:0] i_push_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic signed [sads_pkg::ELEM_W-1:0] o_pop_value,
    output logic [sads_pkg::CNT_W-1:0]    o_total_count,
    output logic                          o_both_empty
);

    sads_pkg::t_mem_req             mem;
    sads_pkg::t_result              res;
    sads_pkg::t_result              r_out;
    logic                           r_out_vld;
    logic [sads_pkg::ELEM_W-1:0]    rdata;
    logic                           out_free;

    assign out_free = !r_out_vld || i_ready;

    sads_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_stack_sel  (i_stack_sel),
        .i_push_value (i_push_value),
        .i_out_free   (out_free),
        .i_rdata      (rdata),
        .o_mem        (mem),
        .o_res        (res)
    );

    sads_ram #(
        .DEPTH (sads_pkg::DEPTH),
        .WIDTH (sads_pkg::ELEM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.vld) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_out.status;
    assign o_pop_value   = r_out.pop_value;
    assign o_total_count = r_out.total;
    assign o_both_empty  = r_out.both_empty;

endmodule

### src/sads_ram.sv
// Element store: single write port, single read port, registered read data.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module sads_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sads_ctrl.sv
// Request sequencer: stack counters, store addressing and result formation.
// Depends on sads_pkg.
`timescale 1ns / 1ps

module sads_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_req_type,
    input  logic                      i_stack_sel,
    input  logic [sads_pkg::ELEM_W-1:0] i_push_value,
    input  logic                      i_out_free,
    input  logic [sads_pkg::ELEM_W-1:0] i_rdata,
    output sads_pkg::t_mem_req        o_mem,
    output sads_pkg::t_result         o_res
);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state                       r_state, n_state;
    logic [sads_pkg::CNT_W-1:0]   r_lower, n_lower;
    logic [sads_pkg::CNT_W-1:0]   r_upper, n_upper;
    logic [sads_pkg::CNT_W-1:0]   cur_total;
    logic [sads_pkg::CNT_W-1:0]   next_total;
    logic [sads_pkg::CNT_W-1:0]   up_pop_pos;
    logic                         accept;
    logic                         pop_fire;
    sads_pkg::t_status            req_status;

    assign o_ready    = (r_state == S_IDLE) && i_out_free;
    assign accept     = i_valid && o_ready;
    assign cur_total  = r_lower + r_upper;
    // top of the upper stack sits at DEPTH - upper_count
    assign up_pop_pos = sads_pkg::CNT_W'(sads_pkg::DEPTH) - r_upper;

    always_comb begin
        n_state     = r_state;
        n_lower     = r_lower;
        n_upper     = r_upper;
        pop_fire    = 1'b0;
        req_status  = sads_pkg::ST_OK;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_lower[sads_pkg::ADDR_W-1:0];
        o_mem.wdata = i_push_value;
        o_mem.re    = 1'b0;
        o_mem.raddr = up_pop_pos[sads_pkg::ADDR_W-1:0];

        if (r_state == S_READ) begin
            n_state = S_IDLE;
        end else if (accept) begin
            unique case (i_req_type)
                sads_pkg::REQ_PUSH: begin
                    if (cur_total == sads_pkg::CNT_W'(sads_pkg::DEPTH)) begin
                        req_status = sads_pkg::ST_FULL;
                    end else if (i_stack_sel == sads_pkg::SEL_LOWER) begin
                        o_mem.we = 1'b1;
                        n_lower  = r_lower + sads_pkg::CNT_W'(1);
                    end else begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = sads_pkg::ADDR_W'(sads_pkg::DEPTH - 1)
                                      - r_upper[sads_pkg::ADDR_W-1:0];
                        n_upper     = r_upper + sads_pkg::CNT_W'(1);
                    end
                end
                sads_pkg::REQ_POP: begin
                    if (i_stack_sel == sads_pkg::SEL_LOWER) begin
                        if (r_lower == '0) begin
                            req_status = sads_pkg::ST_EMPTY;
                        end else begin
                            n_lower     = r_lower - sads_pkg::CNT_W'(1);
                            o_mem.re    = 1'b1;
                            o_mem.raddr = n_lower[sads_pkg::ADDR_W-1:0];
                            pop_fire    = 1'b1;
                        end
                    end else begin
                        if (r_upper == '0) begin
                            req_status = sads_pkg::ST_EMPTY;
                        end else begin
                            n_upper  = r_upper - sads_pkg::CNT_W'(1);
                            o_mem.re = 1'b1;
                            pop_fire = 1'b1;
                        end
                    end
                end
                sads_pkg::REQ_CLEAR: begin
                    n_lower = '0;
                    n_upper = '0;
                end
                default: begin
                end
            endcase
            if (pop_fire) begin
                n_state = S_READ;
            end
        end
    end

    assign next_total = n_lower + n_upper;

    // a pop's result waits in S_READ for the store's registered read data; the
    // output register is known to be empty in that state
    always_comb begin
        o_res.vld        = (r_state == S_READ) || (accept && !pop_fire);
        o_res.status     = (r_state == S_READ) ? sads_pkg::ST_OK : req_status;
        o_res.pop_value  = (r_state == S_READ) ? i_rdata : '0;
        o_res.total      = next_total;
        o_res.both_empty = (next_total == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lower <= '0;
            r_upper <= '0;
        end else begin
            r_state <= n_state;
            r_lower <= n_lower;
            r_upper <= n_upper;
        end
    end

endmodule

### src/sads_chk.sv
// Port-level checker for shared_array_double_stack_core, bound to the top level.
// Depends on sads_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sads_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [1:0]                        o_status,
    input logic [sads_pkg::ELEM_W-1:0]       o_pop_value,
    input logic [sads_pkg::CNT_W-1:0]        o_total_count,
    input logic                              o_both_empty
);

    `SADS_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_pop_value) && $stable(o_total_count), "result changed while stalled")
    `SADS_ASSERT(a_empty_flag, o_valid |-> (o_both_empty == (o_total_count == '0)), "both_empty disagrees with total_count")
    `SADS_ASSERT(a_count_range, o_valid |-> (o_total_count <= sads_pkg::CNT_W'(sads_pkg::DEPTH)), "total_count above store depth")
    `SADS_ASSERT(a_pop_zero, o_valid && (o_status == sads_pkg::ST_FULL || o_status == sads_pkg::ST_EMPTY) |-> (o_pop_value == '0), "pop_value nonzero on a failed request")
    `SADS_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind shared_array_double_stack_core sads_chk u_sads_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_pop_value   (o_pop_value),
    .o_total_count (o_total_count),
    .o_both_empty  (o_both_empty)
);

### test/shared_array_double_stack_core_tb.sv
// Self-checking testbench for shared_array_double_stack_core: directed table, then random traffic.
// Expected results: typed table rows, else shadow stacks; depends on sads_pkg and the core RTL.
`timescale 1ns / 1ps

module shared_array_double_stack_core_tb;

    localparam logic [1:0] REQ_NOP = 2'd3;    // unused code, must act as a no-op
    localparam int RESET_CYCLES = 7;
    localparam int N_ROWS       = 22;
    localparam int N_RANDOM     = 400;
    localparam int QUIET_TAIL   = 60;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        sads_pkg::t_status                 status;
        logic [sads_pkg::ELEM_W-1:0]       pop_value;
        logic [sads_pkg::CNT_W-1:0]        total;
        logic                              both_empty;
    } t_outcome;

    typedef struct packed {
        logic [1:0]                  req;
        logic                        sel;
        logic [sads_pkg::ELEM_W-1:0] val;
        logic [5:0]                  reps;
        logic                        typed;     // 1: outcome column holds the expected result
        t_outcome                    outcome;
    } t_row;

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               i_valid      = 1'b0;
    logic                               o_ready;
    logic [1:0]                         i_req_type   = sads_pkg::REQ_PUSH;
    logic                               i_stack_sel  = sads_pkg::SEL_LOWER;
    logic signed [sads_pkg::ELEM_W-1:0] i_push_value = '0;
    logic                               o_valid;
    logic                               i_ready      = 1'b0;
    logic [1:0]                         o_status;
    logic signed [sads_pkg::ELEM_W-1:0] o_pop_value;
    logic [sads_pkg::CNT_W-1:0]         o_total_count;
    logic                               o_both_empty;

    logic [sads_pkg::ELEM_W-1:0] shadow_store [sads_pkg::DEPTH];
    int                lower_cnt = 0;
    int                upper_cnt = 0;
    t_outcome          pending_results [$];
    t_row              directed_rows [N_ROWS];
    int                mismatches = 0;
    int                cycle_cnt  = 0;
    bit                quiet_tail = 1'b0;
    bit                hold_off_req = 1'b0;

    shared_array_double_stack_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_stack_sel   (i_stack_sel),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_pop_value   (o_pop_value),
        .o_total_count (o_total_count),
        .o_both_empty  (o_both_empty)
    );

    always #5 i_clk = ~i_clk;

    // Shadow stacks: applies one request and returns the result it must produce.
    function automatic t_outcome stack_step(input logic [1:0] req, input logic sel,
                                            input logic [sads_pkg::ELEM_W-1:0] val);
        t_outcome r;
        r = '{sads_pkg::ST_OK, '0, '0, 1'b0};
        case (req)
            sads_pkg::REQ_PUSH: begin
                if (lower_cnt + upper_cnt >= sads_pkg::DEPTH) begin
                    r.status = sads_pkg::ST_FULL;
                end else if (sel == sads_pkg::SEL_LOWER) begin
                    shadow_store[lower_cnt] = val;
                    lower_cnt++;
                end else begin
                    shadow_store[sads_pkg::DEPTH - 1 - upper_cnt] = val;
                    upper_cnt++;
                end
            end
            sads_pkg::REQ_POP: begin
                if (sel == sads_pkg::SEL_LOWER) begin
                    if (lower_cnt == 0) begin
                        r.status = sads_pkg::ST_EMPTY;
                    end else begin
                        lower_cnt--;
                        r.pop_value = shadow_store[lower_cnt];
                    end
                end else begin
                    if (upper_cnt == 0) begin
                        r.status = sads_pkg::ST_EMPTY;
                    end else begin
                        r.pop_value = shadow_store[sads_pkg::DEPTH - upper_cnt];
                        upper_cnt--;
                    end
                end
            end
            sads_pkg::REQ_CLEAR: begin
                lower_cnt = 0;
                upper_cnt = 0;
            end
            default: ;
        endcase
        r.total      = sads_pkg::CNT_W'(lower_cnt + upper_cnt);
        r.both_empty = (lower_cnt + upper_cnt == 0);
        return r;
    endfunction

    function automatic logic [sads_pkg::ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offers one request and returns at the edge where it transfers.
    task automatic send_request(input logic [1:0] req, input logic sel,
                                input logic [sads_pkg::ELEM_W-1:0] val,
                                input logic typed, input t_outcome typed_outcome);
        t_outcome predicted;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_stack_sel  <= sel;
        i_push_value <= val;
        do @(posedge i_clk); while (!o_ready);
        predicted = stack_step(req, sel, val);
        pending_results.push_back(typed ? typed_outcome : predicted);
    endtask

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer: st=%0d pop=%h total=%0d empty=%0b",
                             o_status, o_pop_value, o_total_count, o_both_empty);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status != exp_res.status || o_pop_value != exp_res.pop_value ||
                    o_total_count != exp_res.total || o_both_empty != exp_res.both_empty) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
                                 exp_res.status, exp_res.pop_value, exp_res.total,
                                 exp_res.both_empty, o_status, o_pop_value,
                                 o_total_count, o_both_empty);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int         row;
        int         k;
        int         seq_len;
        int         kind;
        int         rand_done;
        logic       side;
        logic       sel;
        logic [1:0] req;

        directed_rows = '{
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_LOWER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_EMPTY, 32'h0,         6'd0,  1'b1}},
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_UPPER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_EMPTY, 32'h0,         6'd0,  1'b1}},
            '{REQ_NOP,             sads_pkg::SEL_UPPER, 32'hffff_ffff, 6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd0,  1'b1}},
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_LOWER, 32'h7fff_ffff, 6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd1,  1'b0}},
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_UPPER, 32'h8000_0000, 6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd2,  1'b0}},
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_LOWER, 32'hffff_ffff, 6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd3,  1'b0}},
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_LOWER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'hffff_ffff, 6'd2,  1'b0}},
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_UPPER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h8000_0000, 6'd1,  1'b0}},
            // other stack still holds an element, selected one is empty
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_UPPER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_EMPTY, 32'h0,         6'd1,  1'b0}},
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_LOWER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h7fff_ffff, 6'd0,  1'b1}},
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_UPPER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd1,  1'b0}},
            '{sads_pkg::REQ_CLEAR, sads_pkg::SEL_LOWER, 32'h1234_5678, 6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd0,  1'b1}},
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_UPPER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_EMPTY, 32'h0,         6'd0,  1'b1}},
            // fill the whole store from both ends
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_LOWER, 32'h0,         6'd20, 1'b0, '0},
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_UPPER, 32'h0,         6'd12, 1'b0, '0},
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_LOWER, 32'h1,         6'd1,  1'b1,
              '{sads_pkg::ST_FULL,  32'h0,         6'd32, 1'b0}},
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_UPPER, 32'h1,         6'd1,  1'b1,
              '{sads_pkg::ST_FULL,  32'h0,         6'd32, 1'b0}},
            '{REQ_NOP,             sads_pkg::SEL_LOWER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd32, 1'b0}},
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_UPPER, 32'h0,         6'd1,  1'b0, '0},
            // lower stack grows into the slot the upper one just freed
            '{sads_pkg::REQ_PUSH,  sads_pkg::SEL_LOWER, 32'h5555_5555, 6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd32, 1'b0}},
            '{sads_pkg::REQ_POP,   sads_pkg::SEL_LOWER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h5555_5555, 6'd31, 1'b0}},
            '{sads_pkg::REQ_CLEAR, sads_pkg::SEL_UPPER, 32'h0,         6'd1,  1'b1,
              '{sads_pkg::ST_OK,    32'h0,         6'd0,  1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++) begin
            for (k = 0; k < directed_rows[row].reps; k++)
                send_request(directed_rows[row].req, directed_rows[row].sel,
                             (directed_rows[row].reps > 1) ? pick_element()
                                                           : directed_rows[row].val,
                             directed_rows[row].typed, directed_rows[row].outcome);
        end

        // random part: mostly push runs and pop runs that reach full and empty
        hold_off_req = 1'b1;
        rand_done = 0;
        while (rand_done < N_RANDOM) begin
            kind    = $urandom_range(0, 9);
            seq_len = (kind < 7) ? $urandom_range(1, 36) : $urandom_range(1, 10);
            side    = 1'($urandom_range(0, 1));
            for (k = 0; k < seq_len; k++) begin
                if (kind < 4) begin
                    req = sads_pkg::REQ_PUSH;
                    sel = ($urandom_range(0, 3) == 0) ? ~side : side;
                end else if (kind < 7) begin
                    req = sads_pkg::REQ_POP;
                    sel = ($urandom_range(0, 3) == 0) ? ~side : side;
                end else if (kind < 9) begin
                    req = $urandom_range(0, 1) ? sads_pkg::REQ_PUSH : sads_pkg::REQ_POP;
                    sel = 1'($urandom_range(0, 1));
                end else begin
                    req = $urandom_range(0, 1) ? sads_pkg::REQ_CLEAR : REQ_NOP;
                    sel = 1'($urandom_range(0, 1));
                end
                quiet_tail = (rand_done >= N_RANDOM - QUIET_TAIL);
                send_request(req, sel, pick_element(), 1'b0, '0);
                if (req != REQ_NOP)
                    rand_done++;
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/sads_pkg.sv
src/sads_ram.sv
src/sads_ctrl.sv
src/shared_array_double_stack_core.sv
src/sads_chk.sv
test/shared_array_double_stack_core_tb.sv
